/* src/bba_pkg.sv */
package bba_pkg;

  localparam int NUM_UNITS_DEF  = 1024;
  localparam int NUM_ORDERS_DEF = 11;
  localparam int ADDR_BITS_DEF  = 32;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;
  localparam logic [1:0] ST_OUTSIDE = 2'd3;

  localparam int CFG_REGION_BASE = 0;
  localparam int CFG_UNIT_SHIFT  = 1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] start_address;
    logic [31:0] length_bytes;
  } item_in_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic [1:0]  status;
  } item_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the item and compute the unit range
    logic mark_step;  // run one step of the range split
    logic srch_init;  // start the free-block search at the requested order
    logic srch_step;  // move on to the next map bit, or to the next order
    logic take;       // clear the found bit and set up the tail range
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_alloc;
    logic too_big;
    logic mark_done;
    logic hit;
    logic srch_done;
  } dp_stat_t;

endpackage

/* src/bba_ram.sv */
module bba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/bba_ctrl.sv */
module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              clr_done,
  input  bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              finish
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_SRCH  = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_TEST  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    finish     = 1'b0;
    case (state)
      S_CLEAR: begin
        if (clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat.is_alloc) begin
          state_next = S_MARK;
        end else if (stat.too_big) begin
          state_next = S_DONE;
        end else begin
          cmd.srch_init = 1'b1;
          state_next    = S_SRCH;
        end
      end
      S_MARK: begin
        if (stat.mark_done) begin
          state_next = S_DONE;
        end else begin
          cmd.mark_step = 1'b1;
        end
      end
      S_SRCH: begin
        // Read address is presented; data arrives next cycle.
        state_next = S_WAIT;
      end
      S_WAIT: begin
        state_next = S_TEST;
      end
      S_TEST: begin
        if (stat.hit) begin
          cmd.take   = 1'b1;
          state_next = S_MARK;
        end else if (stat.srch_done) begin
          state_next = S_DONE;
        end else begin
          cmd.srch_step = 1'b1;
          state_next    = S_SRCH;
        end
      end
      S_DONE: begin
        finish     = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* src/bba_dp.sv */
module bba_dp #(
  parameter int NUM_UNITS  = bba_pkg::NUM_UNITS_DEF,
  parameter int NUM_ORDERS = bba_pkg::NUM_ORDERS_DEF,
  parameter int ADDR_BITS  = bba_pkg::ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bba_pkg::item_in_t  item_in,
  input  bba_pkg::dp_cmd_t   cmd,
  input  logic               finish,
  input  logic [31:0]        region_base,
  input  logic [3:0]         unit_shift,
  output bba_pkg::dp_stat_t  stat,
  output logic               clr_done,
  output bba_pkg::item_out_t result
);

  localparam int UB = $clog2(NUM_UNITS) + 1;      // unit index incl. end
  localparam int MB = $clog2(2 * NUM_UNITS);      // map address
  localparam int KB = $clog2(NUM_ORDERS + 1);     // order counter
  localparam int SB = 34;                          // byte arithmetic

  // Clearing pass, order search and range split state.
  logic [MB-1:0] clr_addr;
  logic          clearing;
  logic          is_alloc;
  logic [1:0]    status;
  logic [31:0]   baddr;
  logic [UB-1:0] su, eu;
  logic [KB-1:0] mk;
  logic [KB-1:0] sk;
  logic [UB-1:0] sidx;
  logic [MB-1:0] soff;
  logic [KB-1:0] req_k;
  logic          too_big;
  logic [31:0]   size_q;

  logic [3:0] sh;
  assign sh = (unit_shift < 4'd3) ? 4'd3 : ((unit_shift > 4'd12) ? 4'd12 : unit_shift);

  // Combinational decode of the item at load.
  logic [SB-1:0] lo, hi, a, b, a_c, b_c, unitm1;
  logic [SB-1:0] su_w, eu_w;
  logic          outside;
  logic [31:0]   size_w;
  logic [SB-1:0] used_w;
  logic [KB-1:0] k_w;
  logic          big_w;
  always_comb begin
    lo      = SB'(region_base);
    hi      = lo + (SB'(NUM_UNITS) << sh);
    a       = SB'(item_in.start_address);
    b       = a + SB'(item_in.length_bytes);
    outside = (a < lo) || (b > hi);
    a_c     = (a < lo) ? lo : a;
    b_c     = (b > hi) ? hi : b;
    unitm1  = (SB'(1) << sh) - SB'(1);
    su_w    = (a_c - lo + unitm1) >> sh;
    eu_w    = (b_c - lo) >> sh;
    size_w  = (item_in.length_bytes == 32'd0) ? 32'd1 : item_in.length_bytes;
    used_w  = (SB'(size_w) + unitm1) >> sh;
    // Order needed: smallest k with 2^k >= used units (bounded small loop).
    k_w   = KB'(NUM_ORDERS);
    big_w = 1'b1;
    for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
      if ((SB'(1) << k) >= used_w) begin
        k_w   = KB'(k);
        big_w = 1'b0;
      end
    end
  end

  // Order offset in the flat map.
  function automatic logic [MB-1:0] ord_off(input logic [KB-1:0] k);
    logic [MB:0] off;
    off = '0;
    for (int j = 0; j < NUM_ORDERS; j++) begin
      if (KB'(j) < k) off = off + (MB+1)'(NUM_UNITS >> j);
    end
    return off[MB-1:0];
  endfunction

  // Range split step: emits at most one block per cycle.
  logic          last_k;
  logic [UB-1:0] bitv;
  logic          m_we;
  logic [MB-1:0] m_addr;
  logic [UB-1:0] su_n, eu_n;
  logic [KB-1:0] mk_n;
  logic          mk_adv;
  logic [MB-1:0] mk_off;
  always_comb begin
    last_k = (mk == KB'(NUM_ORDERS - 1));
    bitv   = UB'(1) << mk;
    mk_off = ord_off(mk);
    su_n   = su;
    eu_n   = eu;
    mk_n   = mk;
    m_we   = 1'b0;
    m_addr = mk_off + MB'(su >> mk);
    mk_adv = 1'b0;
    if (su < eu) begin
      if (last_k) begin
        m_we = 1'b1;
        su_n = su + bitv;
      end else if ((su & bitv) != '0) begin
        m_we = 1'b1;
        su_n = su + bitv;
      end else if ((eu & bitv) != '0) begin
        m_we   = 1'b1;
        eu_n   = eu - bitv;
        m_addr = mk_off + MB'((eu - bitv) >> mk);
        mk_adv = 1'b1;
      end else begin
        mk_adv = 1'b1;
      end
      if (mk_adv) mk_n = mk + KB'(1);
    end
  end

  // Search bookkeeping.
  logic [UB-1:0] blocks_sk;
  assign blocks_sk = UB'(NUM_UNITS >> sk);
  logic rd_bit;
  logic [MB-1:0] raddr;
  assign raddr = soff + MB'(sidx);

  logic last_idx;
  assign last_idx = (sidx + UB'(1) >= blocks_sk);

  // Map memory write selection.
  logic          we;
  logic [MB-1:0] waddr;
  logic          wdata;
  always_comb begin
    we = 1'b0; waddr = m_addr; wdata = 1'b1;
    if (clearing) begin
      we = 1'b1; waddr = clr_addr; wdata = 1'b0;
    end else if (cmd.take) begin
      we = 1'b1; waddr = raddr; wdata = 1'b0;
    end else if (cmd.mark_step && m_we) begin
      we = 1'b1;
    end
  end

  bba_ram #(.WIDTH(1), .DEPTH(2 * NUM_UNITS)) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_bit)
  );

  // Block address, taken modulo 2^ADDR_BITS.
  logic [SB-1:0] blk_units, blk_bytes;
  logic [63:0]   blk_sum;
  assign blk_units = SB'(sidx) << sk;
  assign blk_bytes = blk_units << sh;
  assign blk_sum   = (64'(region_base) + 64'(blk_bytes))
                     & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - ADDR_BITS));
  logic [SB-1:0] used_q;
  assign used_q = (SB'(size_q) + ((SB'(1) << sh) - SB'(1))) >> sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + MB'(1);
      if (clr_addr == MB'(2 * NUM_UNITS - 1)) clearing <= 1'b0;
    end
    if (cmd.load) begin
      is_alloc <= (item_in.opcode == bba_pkg::OP_ALLOC);
      baddr    <= '0;
      mk       <= '0;
      size_q   <= size_w;
      req_k    <= k_w;
      too_big  <= big_w;
      if (item_in.opcode == bba_pkg::OP_ADD) begin
        status <= (item_in.length_bytes != 32'd0 && outside) ? bba_pkg::ST_OUTSIDE
                                                             : bba_pkg::ST_OK;
        if (item_in.length_bytes != 32'd0 && a_c < b_c && su_w < eu_w) begin
          su <= UB'(su_w);
          eu <= UB'(eu_w);
        end else begin
          su <= '0;
          eu <= '0;
        end
      end else begin
        status <= big_w ? bba_pkg::ST_TOO_BIG : bba_pkg::ST_NO_FREE;
        su     <= '0;
        eu     <= '0;
      end
    end
    if (cmd.mark_step) begin
      su <= su_n;
      eu <= eu_n;
      mk <= mk_n;
    end
    if (cmd.srch_init) begin
      sk   <= req_k;
      soff <= ord_off(req_k);
      sidx <= '0;
    end
    if (cmd.srch_step) begin
      if (last_idx) begin
        sk   <= sk + KB'(1);
        soff <= soff + MB'(blocks_sk);
        sidx <= '0;
      end else begin
        sidx <= sidx + UB'(1);
      end
    end
    if (cmd.take) begin
      status <= bba_pkg::ST_OK;
      baddr  <= blk_sum[31:0];
      mk     <= '0;
      if (used_q < (SB'(1) << sk)) begin
        su <= UB'(blk_units + used_q);
        eu <= UB'(blk_units + (SB'(1) << sk));
      end else begin
        su <= '0;
        eu <= '0;
      end
    end
  end

  assign clr_done       = clearing && (clr_addr == MB'(2 * NUM_UNITS - 1));
  assign stat.is_alloc  = is_alloc;
  assign stat.too_big   = too_big;
  assign stat.mark_done = !(su < eu);
  assign stat.hit       = rd_bit;
  assign stat.srch_done = last_idx && (sk == KB'(NUM_ORDERS - 1));

  always_comb begin
    result.block_address = baddr;
    result.status        = status;
    if (!finish) result = '0;
  end

endmodule

/* src/buddy_block_allocator.sv */
// Channel | Ports                             | Handshake
// input   | start, busy, item_in              | taken when start is high and busy low
// result  | done, item_out                    | one cycle strobe, always taken
// config  | cfg_we, cfg_index, cfg_data       | written at every edge with cfg_we high
//
// An add item works through the split one step at a time, each step marking one block
// or passing over an order (at most two blocks per order below the top order).
// An allocate item scans the order bitmaps one bit at a time, each bit passing through
// the search, wait and test states (registered map read), then splits the tail.
// After reset a clearing pass over all 2*NUM_UNITS map bits runs with busy high.
// The result cannot be stalled by the receiver.
module buddy_block_allocator #(
  parameter int NUM_UNITS  = bba_pkg::NUM_UNITS_DEF,
  parameter int NUM_ORDERS = bba_pkg::NUM_ORDERS_DEF,
  parameter int ADDR_BITS  = bba_pkg::ADDR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bba_pkg::item_in_t   item_in,
  output logic                done,
  output bba_pkg::item_out_t  item_out,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);

  logic [31:0] region_base;
  logic [3:0]  unit_shift;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      unit_shift  <= 4'd3;
    end else if (cfg_we) begin
      if (cfg_index == 1'(bba_pkg::CFG_REGION_BASE)) region_base <= cfg_data;
      else unit_shift <= cfg_data[3:0];
    end
  end

  bba_pkg::dp_cmd_t  cmd;
  bba_pkg::dp_stat_t stat;
  logic              clr_done;
  logic              finish;

  bba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .clr_done(clr_done),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy),
    .finish  (finish)
  );

  bba_dp #(
    .NUM_UNITS (NUM_UNITS),
    .NUM_ORDERS(NUM_ORDERS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .cmd        (cmd),
    .finish     (finish),
    .region_base(region_base),
    .unit_shift (unit_shift),
    .stat       (stat),
    .clr_done   (clr_done),
    .result     (item_out)
  );

  assign done = finish;

endmodule

/* sim/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NU = bba_pkg::NUM_UNITS_DEF;
  localparam int NO = bba_pkg::NUM_ORDERS_DEF;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  bba_pkg::item_in_t item_in;
  logic done;
  bba_pkg::item_out_t item_out;
  logic cfg_we;
  logic cfg_index;
  logic [31:0] cfg_data;

  buddy_block_allocator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item_in(item_in),
    .done(done), .item_out(item_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the allocator: one free bit per block of every order.
  bit free_bits [0:2*NU-1];
  logic [31:0] base_mirror;
  logic [3:0] shift_mirror;

  bba_pkg::item_in_t pending_items[$];
  bba_pkg::item_out_t expected_results[$];
  int sender_idle_pct;
  int mismatches;
  int items_sent;
  int status_seen [0:3];

  function automatic int order_base(int k);
    int off;
    off = 0;
    for (int j = 0; j < k; j++) off += NU >> j;
    return off;
  endfunction

  function automatic void put_bit(int k, longint unsigned idx, bit v);
    if (k < NO && idx < longint'(NU >> k)) free_bits[order_base(k) + int'(idx)] = v;
  endfunction

  function automatic bit get_bit(int k, longint unsigned idx);
    if (k >= NO || idx >= longint'(NU >> k)) return 1'b0;
    return free_bits[order_base(k) + int'(idx)];
  endfunction

  function automatic int eff_shift();
    if (shift_mirror < 3) return 3;
    if (shift_mirror > 12) return 12;
    return int'(shift_mirror);
  endfunction

  // Cut the unit range [s, e) into aligned power-of-two blocks and free them.
  function automatic void free_units(longint unsigned s, longint unsigned e);
    longint unsigned bsz;
    for (int k = 0; s < e && k < NO; k++) begin
      bsz = 64'd1 << k;
      if (k == NO - 1) begin
        while (s < e) begin
          put_bit(k, s >> k, 1'b1);
          s += bsz;
        end
        break;
      end
      if ((s & bsz) != 0) begin
        put_bit(k, s >> k, 1'b1);
        s += bsz;
      end
      if (s < e && (e & bsz) != 0) begin
        e -= bsz;
        put_bit(k, e >> k, 1'b1);
      end
    end
  endfunction

  // Expected outcome of one item; updates the mirrored free map.
  function automatic bba_pkg::item_out_t allocator_outcome(bba_pkg::item_in_t it);
    bba_pkg::item_out_t r;
    int sh;
    int k;
    longint unsigned unit, lo, hi, a, b, sz, su, eu, b0, used, addr;
    sh = eff_shift();
    unit = 64'd1 << sh;
    lo = base_mirror;
    hi = lo + (longint'(NU) << sh);
    r.block_address = '0;
    r.status = bba_pkg::ST_OK;
    if (it.opcode == bba_pkg::OP_ADD) begin
      a = it.start_address;
      b = a + it.length_bytes;
      if (it.length_bytes == 0) return r;
      if (a < lo || b > hi) r.status = bba_pkg::ST_OUTSIDE;
      if (a < lo) a = lo;
      if (b > hi) b = hi;
      if (a < b) begin
        su = (a - lo + unit - 1) >> sh;
        eu = (b - lo) >> sh;
        if (su < eu) free_units(su, eu);
      end
      return r;
    end
    sz = (it.length_bytes == 0) ? 64'd1 : it.length_bytes;
    k = 0;
    while (k < NO && (unit << k) < sz) k++;
    if (k >= NO) begin
      r.status = bba_pkg::ST_TOO_BIG;
      return r;
    end
    for (int j = k; j < NO; j++) begin
      for (int idx = 0; idx < (NU >> j); idx++) begin
        if (get_bit(j, idx)) begin
          b0 = longint'(idx) << j;
          used = (sz + unit - 1) >> sh;
          addr = lo + (b0 << sh);
          put_bit(j, idx, 1'b0);
          if (used < (64'd1 << j)) free_units(b0 + used, b0 + (64'd1 << j));
          r.block_address = addr[31:0];
          return r;
        end
      end
    end
    r.status = bba_pkg::ST_NO_FREE;
    return r;
  endfunction

  // Clock and the overall time limit.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("Timeout waiting for results");
    $display("Test completed with failures");
    $finish;
  end

  // Driver: offers items from the pending queue and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      item_in <= '0;
    end else begin
      logic offer_held;
      offer_held = start && busy;
      if (start && !busy) begin
        expected_results.push_back(allocator_outcome(item_in));
        items_sent++;
      end
      if (!offer_held) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          item_in <= pending_items.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: addr %h status %0d", item_out.block_address,
                   item_out.status);
      end else begin
        bba_pkg::item_out_t want;
        want = expected_results.pop_front();
        status_seen[item_out.status]++;
        if (item_out.block_address !== want.block_address || item_out.status !== want.status)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected addr %h status %0d, got addr %h status %0d",
                     want.block_address, want.status, item_out.block_address,
                     item_out.status);
        end
      end
    end
  end

  // Wait until every item has been sent and answered, sampled away from the edge.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || start || busy || expected_results.size() != 0)
      @(negedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx[0];
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bba_pkg::CFG_REGION_BASE) base_mirror = val;
    else shift_mirror = val[3:0];
  endtask

  function automatic bba_pkg::item_in_t make_item(logic op, longint unsigned sa,
                                                  longint unsigned len);
    bba_pkg::item_in_t it;
    it.opcode = op;
    it.start_address = sa[31:0];
    it.length_bytes = len[31:0];
    return it;
  endfunction

  // Random items: mostly adds inside the region and modest allocations,
  // with some raw noise covering every bit of every field.
  function automatic bba_pkg::item_in_t random_item();
    longint unsigned span;
    int pick;
    span = longint'(NU) << eff_shift();
    pick = $urandom_range(99);
    if (pick < 8)
      return make_item($urandom_range(1), $urandom, $urandom);
    if (pick < 40)
      return make_item(bba_pkg::OP_ADD, base_mirror + $urandom_range(0, span - 1),
                       $urandom_range(1, span / 2));
    if (pick < 45)
      return make_item(bba_pkg::OP_ADD, base_mirror - $urandom_range(0, span),
                       $urandom_range(1, 2 * span));
    if (pick < 90)
      return make_item(bba_pkg::OP_ALLOC, $urandom, $urandom_range(0, span >> 6));
    return make_item(bba_pkg::OP_ALLOC, $urandom, $urandom_range(0, span + 16));
  endfunction

  initial begin
    logic [31:0] bases [0:3];
    logic [3:0] shifts [0:3];
    int idle_modes [0:3];
    longint unsigned span;
    bases = '{32'h0, 32'hFFFF_F000, 32'h0000_1000, 32'h0};
    shifts = '{4'd0, 4'd15, 4'd12, 4'd5};
    idle_modes = '{0, 63, 0, 27};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    sender_idle_pct = 0;
    mismatches = 0;
    items_sent = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    for (int i = 0; i < 2 * NU; i++) free_bits[i] = 1'b0;
    base_mirror = '0;
    shift_mirror = 4'd3;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed items with reset register values: empty map, clipping, edge sizes.
    span = longint'(NU) << 3;
    pending_items.push_back(make_item(bba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 0));
    pending_items.push_back(make_item(bba_pkg::OP_ADD, 0, 0));
    pending_items.push_back(make_item(bba_pkg::OP_ADD, 3, 21));
    pending_items.push_back(make_item(bba_pkg::OP_ADD, 0, span));
    pending_items.push_back(make_item(bba_pkg::OP_ADD, 0, span));
    pending_items.push_back(make_item(bba_pkg::OP_ADD, span - 8, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(bba_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(bba_pkg::OP_ALLOC, 0, 0));
    pending_items.push_back(make_item(bba_pkg::OP_ALLOC, 0, 1));
    pending_items.push_back(make_item(bba_pkg::OP_ALLOC, 0, 13));
    pending_items.push_back(make_item(bba_pkg::OP_ALLOC, 0, span));
    pending_items.push_back(make_item(bba_pkg::OP_ALLOC, 0, span + 1));
    pending_items.push_back(make_item(bba_pkg::OP_ALLOC, 0, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(bba_pkg::OP_ALLOC, 0, span / 2 + 5));
    pending_items.push_back(make_item(bba_pkg::OP_ADD, 100, span));
    pending_items.push_back(make_item(bba_pkg::OP_ALLOC, 0, span / 4));
    wait_idle();

    // Phases with different register settings and sender idling.
    for (int p = 0; p < 4; p++) begin
      write_reg(bba_pkg::CFG_REGION_BASE, (p == 3) ? $urandom : bases[p]);
      write_reg(bba_pkg::CFG_UNIT_SHIFT, shifts[p]);
      sender_idle_pct = idle_modes[p];
      span = longint'(NU) << eff_shift();
      pending_items.push_back(make_item(bba_pkg::OP_ADD, base_mirror, span));
      pending_items.push_back(make_item(bba_pkg::OP_ALLOC, 0, 0));
      for (int n = 0; n < 345; n++) pending_items.push_back(random_item());
      wait_idle();
    end

    $display("Sent %0d items over 5 register settings; results ok %0d, no free %0d,",
             items_sent, status_seen[0], status_seen[1]);
    $display("too big %0d, clipped %0d; %0d mismatches", status_seen[2], status_seen[3],
             mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
src/bba_pkg.sv
src/bba_ram.sv
src/bba_ctrl.sv
src/bba_dp.sv
src/buddy_block_allocator.sv
sim/tb_top.sv
